// ===== rtl/maf_pkg.sv =====
// Shared widths and constants for the moving average filter.
package maf_pkg;

    localparam int WINDOW_MAX = 256;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int WIN_W      = 9;
    localparam int ADDR_W     = $clog2(WINDOW_MAX);
    localparam int N_W        = $clog2(WINDOW_MAX + 1);
    localparam int CNT_W      = $clog2(SUM_W + 1);

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(16);

endpackage

// ===== rtl/moving_average_filter.sv =====
// Top level of the boxcar moving average filter.
//
// The input channel (i_valid, i_sample, o_stall) takes one signed 16-bit
// sample per item, and the output channel (o_valid, o_average, i_stall)
// returns one signed 16-bit average per item: the sum of the last N samples
// divided by N, truncated toward zero. N comes from the window length
// register, written through i_cfg_wr_en and i_cfg_wr_data; the user must
// write it only while the block is idle, as the block does not enforce it.
// A write also empties the window. N of zero counts as one. Samples live
// in a 256-entry ring memory read in the cycle before the read-modify-write
// of the running sum, and per-entry valid bits make entries never written
// since reset or the last register write read as zero. From acceptance an
// item passes the memory read at the accepting edge, the update of the
// running sum, 24 steps of the bit-serial divider and one output load. The
// next item can be taken in the cycle after the load: the block takes a new
// item only once the previous result sits in the output register, so not
// before it is through with the last one. If the receiver stalls, the result
// holds and a finished next result waits inside the block, which then stalls
// its input. Reset empties the window, sets N to 16 and clears o_valid.
module moving_average_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [maf_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [maf_pkg::SAMPLE_W-1:0] o_average,
    input  logic                         i_cfg_wr_en,
    input  logic [maf_pkg::WIN_W-1:0]    i_cfg_wr_data
);
    import maf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_UPD  = 3'b010,
        S_DIV  = 3'b100
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [WIN_W-1:0]       r_window;
    logic [N_W-1:0]         win_n;
    logic [ADDR_W-1:0]      r_pos;
    logic [ADDR_W-1:0]      pos_cur;
    logic [ADDR_W-1:0]      n_pos;
    logic [N_W-1:0]         pos_inc;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic [SAMPLE_W-1:0]    r_mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  r_vld;
    logic [SAMPLE_W-1:0]    r_rd_data;
    logic                   r_rd_vld;
    logic [SAMPLE_W-1:0]    r_x;
    logic [SAMPLE_W-1:0]    old_sample;
    logic                   r_neg;
    logic                   in_acc;
    logic                   out_free;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       div_mag;
    logic [SUM_W-1:0]       div_q;
    logic [SAMPLE_W-1:0]    q_low;
    logic                   r_o_valid;
    logic [SAMPLE_W-1:0]    r_o_average;

    always_comb begin
        if (r_window == '0) begin
            win_n = N_W'(1);
        end else if (N_W'(r_window) > N_W'(WINDOW_MAX)) begin
            win_n = N_W'(WINDOW_MAX);
        end else begin
            win_n = N_W'(r_window);
        end
    end

    assign pos_cur  = (N_W'(r_pos) >= win_n) ? '0 : r_pos;
    assign pos_inc  = N_W'(pos_cur) + N_W'(1);
    assign n_pos    = (pos_inc >= win_n) ? '0 : pos_inc[ADDR_W-1:0];

    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_o_valid || !i_stall;
    assign div_start = (r_state == S_UPD);

    assign old_sample = r_rd_vld ? r_rd_data : '0;
    assign n_sum = r_sum - {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample}
                         + {{(SUM_W-SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x};
    assign div_mag = n_sum[SUM_W-1] ? (-n_sum) : n_sum;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_UPD;
            S_UPD:  n_state = S_DIV;
            S_DIV:  if (div_done && out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_window <= WINDOW_RESET;
            r_pos    <= '0;
            r_sum    <= '0;
            r_vld    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
                r_pos    <= '0;
                r_sum    <= '0;
                r_vld    <= '0;
            end else if (r_state == S_UPD) begin
                r_pos          <= n_pos;
                r_sum          <= n_sum;
                r_vld[pos_cur] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= r_mem[pos_cur];
            r_rd_vld  <= r_vld[pos_cur];
            r_x       <= i_sample;
        end
        if (r_state == S_UPD) begin
            r_mem[pos_cur] <= r_x;
            r_neg          <= n_sum[SUM_W-1];
        end
    end

    maf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_mag),
        .i_divisor  (win_n),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign q_low = div_q[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_DIV) && div_done && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && div_done && out_free) begin
            r_o_average <= r_neg ? (-q_low) : q_low;
        end
    end

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_o_valid;
    assign o_average = r_o_average;

endmodule

// ===== rtl/maf_div.sv =====
// Bit-serial restoring divider for the magnitude of the running sum.
module maf_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [maf_pkg::SUM_W-1:0] i_dividend,
    input  logic [maf_pkg::N_W-1:0]   i_divisor,
    output logic                      o_done,
    output logic [maf_pkg::SUM_W-1:0] o_quotient
);
    import maf_pkg::*;

    logic [SUM_W-1:0] r_dvd;
    logic [N_W-1:0]   r_rem;
    logic [N_W-1:0]   r_div;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W:0]     shifted;
    logic [N_W:0]     diff;
    logic             take;

    assign shifted = {r_rem, r_dvd[SUM_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign take    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(SUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[SUM_W-2:0], take};
            r_rem <= take ? diff[N_W-1:0] : shifted[N_W-1:0];
        end
    end

    assign o_done     = (r_cnt == '0);
    assign o_quotient = r_dvd;

endmodule

// ===== rtl/maf_chk.sv =====
// Port-level assertion checker for the moving average filter, with its bind.
module maf_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [maf_pkg::SAMPLE_W-1:0] o_average,
    input logic                         i_cfg_wr_en
);
    import maf_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("Input not stalled after an item was accepted.");

    a_result_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("Result appeared without an item in progress.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_average)))
        else $error("Stalled result changed.");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |-> (!o_stall && !o_valid))
        else $error("Window length written while an item was in flight.");

endmodule

bind moving_average_filter maf_chk u_maf_chk (.*);
